FILE: rtl/utf8_validate_utf16_length_core_defines.svh
// Assertion macros shared by the UTF-8 validator RTL.
`ifndef UTF8_VALIDATE_UTF16_LENGTH_CORE_DEFINES_SVH
`define UTF8_VALIDATE_UTF16_LENGTH_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8V_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8V_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/u8v_pkg.sv
// Package with shared types, byte classes and constants of the UTF-8 validator.
`timescale 1ns / 1ps
`default_nettype none
package u8v_pkg;

  localparam int COUNT_BITS_DEFAULT  = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int OUT_BITS            = 32;

  // Byte thresholds used by the classifier.
  localparam logic [7:0] BYTE_FOLLOW_LO = 8'h80;
  localparam logic [7:0] BYTE_LEAD2_LO  = 8'hC0;
  localparam logic [7:0] BYTE_LEAD2_OK  = 8'hC2;
  localparam logic [7:0] BYTE_LEAD3_LO  = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4_LO  = 8'hF0;
  localparam logic [7:0] BYTE_LEAD_END  = 8'hF5;
  localparam logic [7:0] BYTE_SURR_LEAD = 8'hED;
  localparam logic [7:0] BYTE_MAX_LEAD  = 8'hF4;
  localparam logic [7:0] BYTE_FOLLOW_A0 = 8'hA0;
  localparam logic [7:0] BYTE_FOLLOW_90 = 8'h90;

  // Byte kinds.
  localparam logic [2:0] KIND_ASCII   = 3'd0;
  localparam logic [2:0] KIND_LEAD2   = 3'd1;
  localparam logic [2:0] KIND_LEAD3   = 3'd2;
  localparam logic [2:0] KIND_LEAD4   = 3'd3;
  localparam logic [2:0] KIND_FOLLOW  = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  // Lead bytes that restrict the range of the first follow byte.
  localparam logic [2:0] LEAD_PLAIN = 3'd0;
  localparam logic [2:0] LEAD_E0    = 3'd1;
  localparam logic [2:0] LEAD_ED    = 3'd2;
  localparam logic [2:0] LEAD_F0    = 3'd3;
  localparam logic [2:0] LEAD_F4    = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] lead;
    logic       ge_a0;
    logic       ge_90;
    logic       last;
  } item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage
`default_nettype wire

FILE: rtl/u8v_front.sv
// Front end: takes input bytes and classifies each one for the back end.
`timescale 1ns / 1ps
`default_nettype none
module u8v_front (
  input  wire logic                   push,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  input  wire u8v_pkg::queue_status_t q_status,
  output logic                        full,
  output logic                        wr_en,
  output u8v_pkg::item_t              wr_item
);
  import u8v_pkg::*;

  assign full  = q_status.full;
  assign wr_en = push && !q_status.full;

  always_comb begin
    wr_item.last  = last_byte;
    wr_item.ge_a0 = (data_byte >= BYTE_FOLLOW_A0);
    wr_item.ge_90 = (data_byte >= BYTE_FOLLOW_90);

    if (data_byte < BYTE_FOLLOW_LO) begin
      wr_item.kind = KIND_ASCII;
    end else if (data_byte < BYTE_LEAD2_LO) begin
      wr_item.kind = KIND_FOLLOW;
    end else if (data_byte < BYTE_LEAD2_OK) begin
      wr_item.kind = KIND_INVALID;
    end else if (data_byte < BYTE_LEAD3_LO) begin
      wr_item.kind = KIND_LEAD2;
    end else if (data_byte < BYTE_LEAD4_LO) begin
      wr_item.kind = KIND_LEAD3;
    end else if (data_byte < BYTE_LEAD_END) begin
      wr_item.kind = KIND_LEAD4;
    end else begin
      wr_item.kind = KIND_INVALID;
    end

    if (data_byte == BYTE_LEAD3_LO) begin
      wr_item.lead = LEAD_E0;
    end else if (data_byte == BYTE_SURR_LEAD) begin
      wr_item.lead = LEAD_ED;
    end else if (data_byte == BYTE_LEAD4_LO) begin
      wr_item.lead = LEAD_F0;
    end else if (data_byte == BYTE_MAX_LEAD) begin
      wr_item.lead = LEAD_F4;
    end else begin
      wr_item.lead = LEAD_PLAIN;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/u8v_queue.sv
// Small queue of classified bytes between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none
module u8v_queue #(
  parameter int QUEUE_DEPTH = u8v_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire u8v_pkg::item_t         wr_item,
  input  wire logic                   rd_en,
  output u8v_pkg::item_t              rd_item,
  output u8v_pkg::queue_status_t      q_status
);
  import u8v_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  item_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign q_status.full      = (count == CNT_FULL);
  assign q_status.not_empty = (count != '0);
  assign do_wr   = wr_en && !q_status.full;
  assign do_rd   = rd_en && q_status.not_empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/u8v_back.sv
// Back end: sequence checking, saturating counts and the result register.
`timescale 1ns / 1ps
`default_nettype none
module u8v_back #(
  parameter int COUNT_BITS = u8v_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire u8v_pkg::item_t                q_item,
  output logic                               q_rd,
  input  wire logic                          pop,
  output logic                               empty,
  output logic [u8v_pkg::OUT_BITS-1:0]       bytes_translated,
  output logic [u8v_pkg::OUT_BITS-1:0]       words_out,
  output logic                               all_valid
);
  import u8v_pkg::*;

  localparam int WIDE_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam logic [WIDE_BITS-1:0] OUT_MAX = WIDE_BITS'({OUT_BITS{1'b1}});

  logic [1:0]            follow_left, follow_left_next;
  logic [2:0]            seq_len, seq_len_next;
  logic [2:0]            lead, lead_next;
  logic                  stopped, stopped_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [COUNT_BITS-1:0] word_count, word_count_next;
  logic                  out_valid;

  logic                  take;
  logic                  first_ok;
  logic                  do_count;
  logic [2:0]            add_len;
  logic [COUNT_BITS:0]   byte_sum;
  logic [COUNT_BITS:0]   word_sum;
  logic [WIDE_BITS-1:0]  byte_wide;
  logic [WIDE_BITS-1:0]  word_wide;

  // A last byte may only enter when the result register is free or being drained.
  assign take  = q_valid && (!q_item.last || !out_valid || pop);
  assign q_rd  = take;
  assign empty = !out_valid;

  always_comb begin
    case (lead)
      LEAD_E0: first_ok = q_item.ge_a0;
      LEAD_ED: first_ok = !q_item.ge_a0;
      LEAD_F0: first_ok = q_item.ge_90;
      LEAD_F4: first_ok = !q_item.ge_90;
      default: first_ok = 1'b1;
    endcase
  end

  always_comb begin
    follow_left_next = follow_left;
    seq_len_next     = seq_len;
    lead_next        = lead;
    stopped_next     = stopped;
    do_count         = 1'b0;
    add_len          = 3'd1;

    if (take && !stopped) begin
      if (follow_left == 2'd0) begin
        case (q_item.kind)
          KIND_ASCII: begin
            do_count = 1'b1;
          end
          KIND_LEAD2: begin
            lead_next        = q_item.lead;
            seq_len_next     = 3'd2;
            follow_left_next = 2'd1;
          end
          KIND_LEAD3: begin
            lead_next        = q_item.lead;
            seq_len_next     = 3'd3;
            follow_left_next = 2'd2;
          end
          KIND_LEAD4: begin
            lead_next        = q_item.lead;
            seq_len_next     = 3'd4;
            follow_left_next = 2'd3;
          end
          default: begin
            stopped_next = 1'b1;
          end
        endcase
      end else if (q_item.kind != KIND_FOLLOW) begin
        stopped_next     = 1'b1;
        follow_left_next = 2'd0;
        seq_len_next     = 3'd0;
      end else if ((({1'b0, follow_left} + 3'd1) == seq_len) && !first_ok) begin
        stopped_next     = 1'b1;
        follow_left_next = 2'd0;
        seq_len_next     = 3'd0;
      end else begin
        follow_left_next = follow_left - 2'd1;
        if (follow_left == 2'd1) begin
          do_count     = 1'b1;
          add_len      = seq_len;
          seq_len_next = 3'd0;
        end
      end
    end

    byte_sum = {1'b0, byte_count} + (COUNT_BITS + 1)'(add_len);
    word_sum = {1'b0, word_count} + (COUNT_BITS + 1)'((add_len == 3'd4) ? 2'd2 : 2'd1);

    if (do_count) begin
      byte_count_next = byte_sum[COUNT_BITS] ? '1 : byte_sum[COUNT_BITS-1:0];
      word_count_next = word_sum[COUNT_BITS] ? '1 : word_sum[COUNT_BITS-1:0];
    end else begin
      byte_count_next = byte_count;
      word_count_next = word_count;
    end

    byte_wide = WIDE_BITS'(byte_count_next);
    word_wide = WIDE_BITS'(word_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      follow_left <= '0;
      seq_len     <= '0;
      lead        <= LEAD_PLAIN;
      stopped     <= 1'b0;
      byte_count  <= '0;
      word_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take && q_item.last) begin
        // The buffer ends here: the state starts over for the next buffer.
        follow_left <= '0;
        seq_len     <= '0;
        lead        <= LEAD_PLAIN;
        stopped     <= 1'b0;
        byte_count  <= '0;
        word_count  <= '0;
        out_valid   <= 1'b1;
      end else begin
        follow_left <= follow_left_next;
        seq_len     <= seq_len_next;
        lead        <= lead_next;
        stopped     <= stopped_next;
        byte_count  <= byte_count_next;
        word_count  <= word_count_next;
        if (pop) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_item.last) begin
      bytes_translated <= (byte_wide > OUT_MAX) ? '1 : byte_wide[OUT_BITS-1:0];
      words_out        <= (word_wide > OUT_MAX) ? '1 : word_wide[OUT_BITS-1:0];
      all_valid        <= !stopped_next && (follow_left_next == 2'd0);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/utf8_validate_utf16_length_core.sv
// Top level of the UTF-8 validator with UTF-16 length count.
// The block takes one byte of a UTF-8 buffer per cycle on a queue-style port and
// gives one result per buffer, on the byte marked last: the number of bytes in
// complete valid sequences before the first error or truncated tail, the UTF-16
// code units those bytes need (saturating counts) and a flag for a fully valid
// buffer. A new byte is accepted in every cycle while the internal queue has room;
// the back end handles each byte in its sequence state and counter update, which
// form the loop that sets that rate. An accepted last byte is written into the
// queue, and the back end loads the result register from it once that register is
// free or being popped; the result then stays on the ports until it is popped. Only
// a last byte waits for the result register to be drained, so a stall on the result
// side holds back input after the queue fills.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_validate_utf16_length_core_defines.svh"
module utf8_validate_utf16_length_core #(
  parameter int COUNT_BITS  = u8v_pkg::COUNT_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = u8v_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [u8v_pkg::OUT_BITS-1:0]     bytes_translated,
  output logic [u8v_pkg::OUT_BITS-1:0]     words_out,
  output logic                             all_valid
);
  import u8v_pkg::*;

  queue_status_t q_status;
  item_t         wr_item;
  item_t         rd_item;
  logic          wr_en;
  logic          rd_en;
  logic          take_last;

  u8v_front u_front (
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_status  (q_status),
    .full      (full),
    .wr_en     (wr_en),
    .wr_item   (wr_item)
  );

  u8v_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_item  (wr_item),
    .rd_en    (rd_en),
    .rd_item  (rd_item),
    .q_status (q_status)
  );

  u8v_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_status.not_empty),
    .q_item           (rd_item),
    .q_rd             (rd_en),
    .pop              (pop),
    .empty            (empty),
    .bytes_translated (bytes_translated),
    .words_out        (words_out),
    .all_valid        (all_valid)
  );

  assign take_last = rd_en && rd_item.last;

  // A result only appears after the back end has taken a last byte.
  `U8V_ASSERT_IMPLIES(a_result_from_last, clk, rst, (!empty && $past(empty)), $past(take_last), "result appeared without a last byte")
  // A last byte held back by a full result register stays in the queue.
  `U8V_ASSERT_NEXT(a_stalled_last_kept, clk, rst, (q_status.not_empty && rd_item.last && !empty && !pop), q_status.not_empty, "stalled last byte was lost")
  // Every sequence needs at least as many bytes as UTF-16 code units.
  `U8V_ASSERT_IMPLIES(a_words_le_bytes, clk, rst, !empty, (words_out <= bytes_translated), "word count exceeds byte count")

endmodule
`default_nettype wire

FILE: tb/tb_utf8_validate_utf16_length_core.sv
// Self-checking testbench for the UTF-8 validator with UTF-16 length count.
`timescale 1ns / 1ps
module tb_utf8_validate_utf16_length_core;
  import u8v_pkg::*;

  typedef struct packed {
    logic [OUT_BITS-1:0] nbytes;
    logic [OUT_BITS-1:0] units;
    logic                ok;
  } length_result_t;

  typedef struct packed {
    logic [7:0]          d;
    logic                l;
    logic                typed;
    logic [OUT_BITS-1:0] nbytes;
    logic [OUT_BITS-1:0] units;
    logic                ok;
  } stim_row_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_LEAD,
    FLAW_BAD_FOLLOW,
    FLAW_OVERLONG3,
    FLAW_OVERLONG4,
    FLAW_SURROGATE,
    FLAW_TOO_HIGH,
    FLAW_TRUNCATED,
    FLAW_COUNT
  } flaw_t;

  localparam int NUM_ROWS     = 26;
  localparam int RANDOM_BYTES = 820;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          data_byte = 8'h00;
  logic                last_byte = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [OUT_BITS-1:0] bytes_translated;
  logic [OUT_BITS-1:0] words_out;
  logic                all_valid;

  utf8_validate_utf16_length_core u_top (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .empty            (empty),
    .pop              (pop),
    .bytes_translated (bytes_translated),
    .words_out        (words_out),
    .all_valid        (all_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state for the buffer in progress.
  logic [1:0]          seq_pending;
  logic [2:0]          seq_len;
  logic [7:0]          seq_lead;
  logic                buf_err;
  logic [OUT_BITS-1:0] byte_total;
  logic [OUT_BITS-1:0] unit_total;

  length_result_t pending_results[$];
  length_result_t head;
  logic [7:0]     buf_q[$];
  stim_row_t      dir_rows [0:NUM_ROWS-1];

  bit calm = 1'b0;
  int errors = 0;
  int n_sent = 0;
  int n_used = 0;
  int n_buffers = 0;
  int n_clean = 0;
  int n_checked = 0;

  function automatic logic [OUT_BITS-1:0] sat_add(input logic [OUT_BITS-1:0] a, input int n);
    if (a > {OUT_BITS{1'b1}} - OUT_BITS'(n)) return {OUT_BITS{1'b1}};
    return a + OUT_BITS'(n);
  endfunction

  function automatic bit first_follow_ok(input logic [7:0] lead, input logic [7:0] b);
    case (lead)
      BYTE_LEAD3_LO:  return b >= BYTE_FOLLOW_A0;
      BYTE_SURR_LEAD: return b < BYTE_FOLLOW_A0;
      BYTE_LEAD4_LO:  return b >= BYTE_FOLLOW_90;
      BYTE_MAX_LEAD:  return b < BYTE_FOLLOW_90;
      default:        return 1'b1;
    endcase
  endfunction

  task automatic clear_buffer_state();
    seq_pending = '0;
    seq_len     = '0;
    seq_lead    = '0;
    buf_err     = 1'b0;
    byte_total  = '0;
    unit_total  = '0;
  endtask

  task automatic count_seq(input int len);
    byte_total = sat_add(byte_total, len);
    unit_total = sat_add(unit_total, (len == 4) ? 2 : 1);
  endtask

  task automatic halt_buffer();
    buf_err     = 1'b1;
    seq_pending = '0;
    seq_len     = '0;
  endtask

  task automatic start_seq(input logic [7:0] b, input int len);
    seq_lead    = b;
    seq_len     = 3'(len);
    seq_pending = 2'(len - 1);
  endtask

  // Advances the predictor by one byte; used is low for bytes the block ignores.
  task automatic utf8_step(input logic [7:0] b, input logic l, output bit used,
                           output bit has_res, output length_result_t res);
    used    = !buf_err;
    has_res = 1'b0;
    res     = '0;
    if (!buf_err) begin
      if (seq_pending == 0) begin
        if (b < BYTE_FOLLOW_LO) count_seq(1);
        else if (b >= BYTE_LEAD2_OK && b < BYTE_LEAD3_LO) start_seq(b, 2);
        else if (b >= BYTE_LEAD3_LO && b < BYTE_LEAD4_LO) start_seq(b, 3);
        else if (b >= BYTE_LEAD4_LO && b < BYTE_LEAD_END) start_seq(b, 4);
        else halt_buffer();
      end else if (b[7:6] != 2'b10) begin
        halt_buffer();
      end else if (int'(seq_len) - int'(seq_pending) == 1 && !first_follow_ok(seq_lead, b)) begin
        halt_buffer();
      end else begin
        seq_pending = seq_pending - 2'd1;
        if (seq_pending == 0) begin
          count_seq(int'(seq_len));
          seq_len = '0;
        end
      end
    end
    if (l) begin
      has_res    = 1'b1;
      res.nbytes = byte_total;
      res.units  = unit_total;
      res.ok     = !buf_err && seq_pending == 0;
      clear_buffer_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                           input length_result_t typed_res);
    bit             used;
    bit             has_res;
    length_result_t res;
    while (!calm && $urandom_range(0, 99) < 13) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (full);
    n_sent++;
    utf8_step(d, l, used, has_res, res);
    if (used) n_used++;
    if (has_res) begin
      pending_results.push_back(typed ? typed_res : res);
      n_buffers++;
      if (res.ok) n_clean++;
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_follow();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic int unsigned pick_cp(input int n);
    int unsigned lo;
    int unsigned hi;
    bit          at_bound;
    at_bound = ($urandom_range(0, 4) == 0);
    case (n)
      1: begin lo = 32'h0;     hi = 32'h7F;     end
      2: begin lo = 32'h80;    hi = 32'h7FF;    end
      3: begin
        if ($urandom_range(0, 1) != 0) begin lo = 32'h800; hi = 32'hD7FF; end
        else begin lo = 32'hE000; hi = 32'hFFFF; end
      end
      default: begin lo = 32'h10000; hi = 32'h10FFFF; end
    endcase
    if (at_bound) return ($urandom_range(0, 1) != 0) ? lo : hi;
    return $urandom_range(hi, lo);
  endfunction

  task automatic append_cp(input int unsigned cp, output int len);
    if (cp < 32'h80) begin
      len = 1;
      buf_q.push_back(8'(cp));
    end else if (cp < 32'h800) begin
      len = 2;
      buf_q.push_back(8'(32'hC0 | (cp >> 6)));
      buf_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else if (cp < 32'h10000) begin
      len = 3;
      buf_q.push_back(8'(32'hE0 | (cp >> 12)));
      buf_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      buf_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else begin
      len = 4;
      buf_q.push_back(8'(32'hF0 | (cp >> 18)));
      buf_q.push_back(8'(32'h80 | ((cp >> 12) & 32'h3F)));
      buf_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      buf_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end
  endtask

  // Mostly well-formed buffers with the odd flaw; a few are plain noise.
  task automatic build_buffer();
    int    nseq;
    int    len;
    int    k;
    int    cut;
    flaw_t flaw;
    buf_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom));
      return;
    end
    nseq = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    for (k = 0; k < nseq; k++) begin
      flaw = ($urandom_range(0, 99) < 6) ? flaw_t'($urandom_range(1, FLAW_COUNT - 1))
                                         : FLAW_NONE;
      case (flaw)
        FLAW_BAD_LEAD: begin
          if ($urandom_range(0, 1) != 0) buf_q.push_back(8'($urandom_range(8'h80, 8'hC1)));
          else buf_q.push_back(8'($urandom_range(8'hF5, 8'hFF)));
        end
        FLAW_BAD_FOLLOW: begin
          append_cp(pick_cp($urandom_range(2, 4)), len);
          cut = $urandom_range(1, len - 1);
          if ($urandom_range(0, 1) != 0)
            buf_q[buf_q.size() - cut] = 8'($urandom_range(8'h00, 8'h7F));
          else
            buf_q[buf_q.size() - cut] = 8'($urandom_range(8'hC0, 8'hFF));
        end
        FLAW_OVERLONG3: begin
          buf_q.push_back(BYTE_LEAD3_LO);
          buf_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
          buf_q.push_back(rand_follow());
        end
        FLAW_OVERLONG4: begin
          buf_q.push_back(BYTE_LEAD4_LO);
          buf_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
          buf_q.push_back(rand_follow());
          buf_q.push_back(rand_follow());
        end
        FLAW_SURROGATE: begin
          buf_q.push_back(BYTE_SURR_LEAD);
          buf_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
          buf_q.push_back(rand_follow());
        end
        FLAW_TOO_HIGH: begin
          buf_q.push_back(BYTE_MAX_LEAD);
          buf_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
          buf_q.push_back(rand_follow());
          buf_q.push_back(rand_follow());
        end
        FLAW_TRUNCATED: begin
          // A cut sequence only counts as truncated when it ends the buffer.
          append_cp(pick_cp($urandom_range(2, 4)), len);
          repeat ($urandom_range(1, len - 1)) void'(buf_q.pop_back());
          return;
        end
        default: append_cp(pick_cp($urandom_range(1, 4)), len);
      endcase
    end
  endtask

  // Result side: random pop, checked against the oldest pending transaction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_checked++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: bytes %0d words %0d valid %0b",
                   $time, bytes_translated, words_out, all_valid);
          errors++;
        end else begin
          head = pending_results.pop_front();
          if (bytes_translated !== head.nbytes) begin
            $display("%0t: bytes_translated expected %0d actual %0d",
                     $time, head.nbytes, bytes_translated);
            errors++;
          end
          if (words_out !== head.units) begin
            $display("%0t: words_out expected %0d actual %0d", $time, head.units, words_out);
            errors++;
          end
          if (all_valid !== head.ok) begin
            $display("%0t: all_valid expected %0b actual %0b", $time, head.ok, all_valid);
            errors++;
          end
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  initial begin
    int  i;
    int  start_sent;
    bit  paused;
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, 32'd1, 32'd1, 1'b1},  // smallest ASCII
      '{8'h7F, 1'b1, 1'b1, 32'd1, 32'd1, 1'b1},  // largest ASCII
      '{8'h80, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // stray follow byte as lead
      '{8'hC1, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // overlong two-byte lead
      '{8'hF5, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // lead beyond U+10FFFF
      '{8'hFF, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h41, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // ignored after the error
      '{8'hC2, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // truncated tail
      '{8'hC2, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'hBF, 1'b1, 1'b1, 32'd2, 32'd1, 1'b1},
      '{8'hE0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'hA0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 32'd3, 32'd1, 1'b1},  // smallest three-byte value
      '{8'hE0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h9F, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // overlong three-byte form
      '{8'hED, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'hA0, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // surrogate
      '{8'hF0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h90, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'hBF, 1'b1, 1'b1, 32'd4, 32'd2, 1'b1},  // four bytes, two code units
      '{8'hF4, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h90, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0},  // above U+10FFFF
      '{8'h41, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0},
      '{8'h28, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0}   // bad follow byte
    };
    clear_buffer_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_ROWS; i++)
      send_byte(dir_rows[i].d, dir_rows[i].l, dir_rows[i].typed,
                '{dir_rows[i].nbytes, dir_rows[i].units, dir_rows[i].ok});

    start_sent = n_sent;
    paused     = 1'b0;
    while (n_sent - start_sent < RANDOM_BYTES) begin
      calm = (n_sent - start_sent >= 300) && (n_sent - start_sent < 450);
      if (!paused && n_sent - start_sent >= 550) begin
        drain_results();
        paused = 1'b1;
      end
      build_buffer();
      for (i = 0; i < buf_q.size(); i++)
        send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, '0);
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d buffers (%0d fully valid), %0d bytes sent, %0d of them examined.",
             n_buffers, n_clean, n_sent, n_used);
    $display("%0d results checked.", n_checked);
    if (errors == 0) begin
      $display("utf8_validate_utf16_length_core test passed");
    end else begin
      $display("utf8_validate_utf16_length_core test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results still pending.", pending_results.size());
    $display("utf8_validate_utf16_length_core test failed");
    $finish;
  end

endmodule
